// ----- rtl/route_prefix_table_lookup_unit_macros.svh -----
// ---------------------------------------------------------------------------
// route prefix table lookup: assertion macros
// concurrent checks clocked on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef ROUTE_PREFIX_TABLE_LOOKUP_UNIT_MACROS_SVH
`define ROUTE_PREFIX_TABLE_LOOKUP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RPTL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rptl check failed");
`define RPTL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rptl implication failed");
`define RPTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rptl next-cycle check failed");
`else
`define RPTL_ASSERT(lbl, prop)
`define RPTL_ASSERT_IMPL(lbl, ante, cons)
`define RPTL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/rptl_pkg.sv -----
// ---------------------------------------------------------------------------
// rptl_pkg
// shared widths, codes and link types of the route prefix table
// ---------------------------------------------------------------------------
package rptl_pkg;

  localparam int KEY_W      = 24;
  localparam int IFACE_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 16;
  localparam int DEF_TABLE_ENTRIES = 64;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEFAULT = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOROUTE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_STORED  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               ins_en;
    logic [KEY_W-1:0]   key;
    logic [IFACE_W-1:0] iface;
  } rptl_ctrl_t;

  // handed from one cell to its right neighbor
  typedef struct packed {
    logic               valid;
    logic               gt;
    logic               match;
    logic [KEY_W-1:0]   key;
    logic [IFACE_W-1:0] iface;
  } rptl_link_t;

  // per-cell lookup answer, zero unless this cell holds the first match
  typedef struct packed {
    logic               hit;
    logic [IFACE_W-1:0] iface;
  } rptl_leaf_t;

endpackage

// ----- rtl/rptl_cell.sv -----
// ---------------------------------------------------------------------------
// rptl_cell
// one slot of the sorted route row: insert by shifting, exact-match compare
// ---------------------------------------------------------------------------
module rptl_cell
  import rptl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rptl_ctrl_t ctrl,
  input  rptl_link_t left,
  output rptl_link_t right,
  output rptl_leaf_t leaf
);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [IFACE_W-1:0] iface;
  logic               match;
  logic               gt;
  logic               first;

  // empty slots count as greater, so the row splits at the upper bound
  assign gt    = !valid || (key > ctrl.key);
  assign first = match && !left.match;

  assign right.valid = valid;
  assign right.gt    = gt;
  assign right.match = match;
  assign right.key   = key;
  assign right.iface = iface;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins_en && gt) begin
      valid <= left.gt ? left.valid : 1'b1;
    end
  end

  // first slot above the bound takes the new route, the rest shift right
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && gt) begin
      key   <= left.gt ? left.key   : ctrl.key;
      iface <= left.gt ? left.iface : ctrl.iface;
    end
  end

  always_ff @(posedge clk) begin
    match      <= valid && (key == ctrl.key);
    leaf.hit   <= first;
    leaf.iface <= first ? iface : '0;
  end

endmodule

// ----- rtl/rptl_tree.sv -----
// ---------------------------------------------------------------------------
// rptl_tree
// registered binary or-tree that gathers the single matching cell answer
// ---------------------------------------------------------------------------
module rptl_tree
  import rptl_pkg::*;
#(
  parameter int LEAVES = DEF_TABLE_ENTRIES
)
(
  input  logic       clk,
  input  rptl_leaf_t leaf [LEAVES],
  output rptl_leaf_t root
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int PAD    = 1 << LEVELS;

  // heap order: node k has children 2k and 2k+1, leaves start at PAD
  rptl_leaf_t node [1:2*PAD-1];

  genvar gi;
  generate
    for (gi = 0; gi < PAD; gi++) begin : g_leaf
      if (gi < LEAVES) begin : g_used
        assign node[PAD+gi] = leaf[gi];
      end else begin : g_pad
        assign node[PAD+gi] = '0;
      end
    end
    for (gi = 1; gi < PAD; gi++) begin : g_node
      always_ff @(posedge clk) begin
        node[gi] <= node[2*gi] | node[2*gi+1];
      end
    end
  endgenerate

  assign root = node[1];

endmodule

// ----- rtl/route_prefix_table_lookup_unit.sv -----
// ---------------------------------------------------------------------------
// route_prefix_table_lookup_unit
// sorted 24-bit prefix route table held in a row of cells, exact-match lookup
// ---------------------------------------------------------------------------
//   channel  direction  tdata / tuser
//   s_*      in         tdata: prefix, iface, address; tuser: func
//   m_*      out        tdata: status, out_iface
//
// a load: accept, then a shifting insert in the row
// a lookup passes through the compare and first-match registers in the cells
// and then through the registered levels of the or-tree
// one item is in flight; a new word is taken while the last result waits
// a stalled m side holds the finished result and the controller in its state
// rst empties the table and clears the default route
// ---------------------------------------------------------------------------
`include "route_prefix_table_lookup_unit_macros.svh"

module route_prefix_table_lookup_unit
  import rptl_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // prefix[23:0], iface[31:24], address[63:32]
  input  logic                s_tuser,   // func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // status[2:0], out_iface[10:3], zero fill
);

  localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
  localparam int LEVELS      = $clog2(TABLE_ENTRIES);
  localparam int SEARCH_WAIT = LEVELS + 2;
  localparam int WAIT_W      = $clog2(SEARCH_WAIT + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INSERT = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam rptl_link_t HEAD = '{valid: 1'b1, gt: 1'b0, match: 1'b0,
                                  key: '0, iface: '0};

  logic [1:0]          state;
  logic [CNT_W-1:0]    entry_count;
  logic [WAIT_W-1:0]   wait_cnt;
  logic                default_valid;
  logic [IFACE_W-1:0]  default_iface;
  logic [KEY_W-1:0]    op_key;
  logic [IFACE_W-1:0]  op_iface;
  logic [STATUS_W-1:0] res_status;
  logic [IFACE_W-1:0]  res_iface;
  logic                full;
  logic                in_fire;
  logic                out_free;
  logic [KEY_W-1:0]    in_prefix;
  logic [IFACE_W-1:0]  in_iface;
  logic [ADDR_W-1:0]   in_address;
  rptl_ctrl_t          ctrl;
  rptl_link_t          link_out [TABLE_ENTRIES];
  rptl_leaf_t          leaf     [TABLE_ENTRIES];
  rptl_leaf_t          root;
  logic [TABLE_ENTRIES-1:0] hit_vec;

  assign in_prefix  = s_tdata[KEY_W-1:0];
  assign in_iface   = s_tdata[KEY_W+IFACE_W-1:KEY_W];
  assign in_address = s_tdata[KEY_W+IFACE_W+ADDR_W-1:KEY_W+IFACE_W];

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (entry_count == CNT_W'(TABLE_ENTRIES));

  assign ctrl.ins_en = (state == S_INSERT) && !full;
  assign ctrl.key    = op_key;
  assign ctrl.iface  = op_iface;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        rptl_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctrl  (ctrl),
          .left  (HEAD),
          .right (link_out[gi]),
          .leaf  (leaf[gi])
        );
      end else begin : g_body
        rptl_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctrl  (ctrl),
          .left  (link_out[gi-1]),
          .right (link_out[gi]),
          .leaf  (leaf[gi])
        );
      end
      assign hit_vec[gi] = leaf[gi].hit;
    end
  endgenerate

  rptl_tree #(
    .LEAVES (TABLE_ENTRIES)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      wait_cnt      <= '0;
      default_valid <= 1'b0;
      default_iface <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser == FUNC_LOAD) begin
              if (in_prefix == '0) begin
                default_valid <= 1'b1;
                default_iface <= in_iface;
              end
              state <= S_INSERT;
            end else begin
              wait_cnt <= WAIT_W'(SEARCH_WAIT);
              state    <= S_SEARCH;
            end
          end
        end
        S_INSERT: begin
          if (!full) begin
            entry_count <= entry_count + 1'b1;
          end
          state <= S_DONE;
        end
        S_SEARCH: begin
          if (wait_cnt == '0) begin
            state <= S_DONE;
          end else begin
            wait_cnt <= wait_cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_key   <= (s_tuser == FUNC_LOAD) ? in_prefix : in_address[ADDR_W-1:ADDR_W-KEY_W];
      op_iface <= in_iface;
    end
    if (state == S_INSERT) begin
      res_status <= full ? STATUS_FULL : STATUS_STORED;
      res_iface  <= '0;
    end else if (state == S_SEARCH && wait_cnt == '0) begin
      if (root.hit) begin
        res_status <= STATUS_MATCH;
        res_iface  <= root.iface;
      end else if (default_valid) begin
        res_status <= STATUS_DEFAULT;
        res_iface  <= default_iface;
      end else begin
        res_status <= STATUS_NOROUTE;
        res_iface  <= '0;
      end
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {{(M_DATA_W-STATUS_W-IFACE_W){1'b0}}, res_iface, res_status};
    end
  end

  // sorted row keeps equal keys together, so only one cell can be first
  `RPTL_ASSERT(a_one_first_match, $onehot0(hit_vec))
  `RPTL_ASSERT(a_count_bound, entry_count <= CNT_W'(TABLE_ENTRIES))
  `RPTL_ASSERT_IMPL(a_last_cell_full, link_out[TABLE_ENTRIES-1].valid, full)
  `RPTL_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready)

endmodule
